// ----- src/dda_pkg.sv -----
`default_nettype none

package dda_pkg;

  // selector carried on the input tuser
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // command kind held in the queue between front and back
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } dda_cmd_e;

  // front sequencer
  typedef enum logic [2:0] {
    FS_IDLE,
    FS_DELTA,
    FS_MAG,
    FS_STEPS,
    FS_LOAD,
    FS_DIV,
    FS_PUSH
  } dda_fst_e;

endpackage

`default_nettype wire

// ----- src/dda_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle
// quotient = ((mag << F) + div/2) / div, with mag <= div and div != 0
module dda_div #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] mag_i,
  input  logic [COORD_BITS-1:0] div_i,
  output logic [FRAC_BITS:0]    quo_o,
  output logic                  done_o
);

  localparam int unsigned NW = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(FRAC_BITS + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [FRAC_BITS:0]    low_q, low_d;
  logic [COORD_BITS-1:0] div_q, div_d;
  logic [NW-1:0]         num;
  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;
  logic                  ge;

  assign num   = {1'b0, mag_i, {FRAC_BITS{1'b0}}} + NW'(div_i >> 1);
  assign trial = {rem_q, low_q[FRAC_BITS]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num[NW-1:FRAC_BITS+1];
      low_d  = num[FRAC_BITS:0];
      div_d  = div_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      low_d = {low_q[FRAC_BITS-1:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(FRAC_BITS)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    div_q <= div_d;
  end

  assign quo_o  = low_q;
  assign done_o = done_q;

  // partial remainder always stays below the divisor
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// ----- src/dda_front.sv -----
`default_nettype none

// accepts items, sets up a new line (deltas, step count, increments) and
// pushes start and step commands into the queue
module dda_front #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic signed [COORD_BITS-1:0] x_start_i,
  input  logic signed [COORD_BITS-1:0] y_start_i,
  input  logic signed [COORD_BITS-1:0] x_end_i,
  input  logic signed [COORD_BITS-1:0] y_end_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output dda_pkg::dda_cmd_e            push_kind_o,
  output logic signed [COORD_BITS-1:0] push_xa_o,
  output logic signed [COORD_BITS-1:0] push_ya_o,
  output logic signed [FRAC_BITS+1:0]  push_xinc_o,
  output logic signed [FRAC_BITS+1:0]  push_yinc_o,
  output logic [COORD_BITS-1:0]        push_steps_o
);

  import dda_pkg::*;

  dda_fst_e state_q, state_d;

  logic signed [COORD_BITS-1:0] xa_q, ya_q, xb_q, yb_q;
  logic signed [COORD_BITS:0]   dx_q, dy_q;
  logic [COORD_BITS-1:0]        adx_q, ady_q, steps_q;
  logic                         xneg_q, yneg_q;
  logic [COORD_BITS:0]          adx_full, ady_full;
  logic                         accept;
  logic                         div_start;
  logic                         done_x, done_y;
  logic [FRAC_BITS:0]           quo_x, quo_y;
  logic signed [FRAC_BITS+1:0]  qx_s, qy_s;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    push_valid_o = 1'b0;
    push_kind_o  = CMD_START;
    div_start    = 1'b0;
    case (state_q)
      FS_IDLE: begin
        in_ready_o = push_ready_i;
        if (in_valid_i && push_ready_i) begin
          if (func_i == FUNC_STEP) begin
            push_valid_o = 1'b1;
            push_kind_o  = CMD_STEP;
          end else begin
            state_d = FS_DELTA;
          end
        end
      end
      FS_DELTA: state_d = FS_MAG;
      FS_MAG:   state_d = FS_STEPS;
      FS_STEPS: state_d = FS_LOAD;
      FS_LOAD: begin
        if (steps_q != '0) begin
          div_start = 1'b1;
          state_d   = FS_DIV;
        end else begin
          state_d = FS_PUSH;
        end
      end
      FS_DIV: begin
        if (done_x && done_y) begin
          state_d = FS_PUSH;
        end
      end
      FS_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign adx_full = dx_q[COORD_BITS] ? -dx_q : dx_q;
  assign ady_full = dy_q[COORD_BITS] ? -dy_q : dy_q;

  always_ff @(posedge clk_i) begin
    if (accept && func_i == FUNC_START) begin
      xa_q <= x_start_i;
      ya_q <= y_start_i;
      xb_q <= x_end_i;
      yb_q <= y_end_i;
    end
    if (state_q == FS_DELTA) begin
      dx_q <= {xb_q[COORD_BITS-1], xb_q} - {xa_q[COORD_BITS-1], xa_q};
      dy_q <= {yb_q[COORD_BITS-1], yb_q} - {ya_q[COORD_BITS-1], ya_q};
    end
    if (state_q == FS_MAG) begin
      adx_q  <= adx_full[COORD_BITS-1:0];
      ady_q  <= ady_full[COORD_BITS-1:0];
      xneg_q <= dx_q[COORD_BITS];
      yneg_q <= dy_q[COORD_BITS];
    end
    if (state_q == FS_STEPS) begin
      steps_q <= (adx_q > ady_q) ? adx_q : ady_q;
    end
  end

  dda_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .mag_i  (adx_q),
    .div_i  (steps_q),
    .quo_o  (quo_x),
    .done_o (done_x)
  );

  dda_div #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .mag_i  (ady_q),
    .div_i  (steps_q),
    .quo_o  (quo_y),
    .done_o (done_y)
  );

  // sign goes back on the magnitude quotient; zero-length line has no slope
  assign qx_s = {1'b0, quo_x};
  assign qy_s = {1'b0, quo_y};

  always_comb begin
    push_xinc_o = '0;
    push_yinc_o = '0;
    if (steps_q != '0) begin
      push_xinc_o = xneg_q ? -qx_s : qx_s;
      push_yinc_o = yneg_q ? -qy_s : qy_s;
    end
  end

  assign push_xa_o    = xa_q;
  assign push_ya_o    = ya_q;
  assign push_steps_o = steps_q;

endmodule

`default_nettype wire

// ----- src/dda_fifo.sv -----
`default_nettype none

// two-entry command queue
module dda_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned NW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    count_q;
  logic             push, pop;

  assign push_ready_o = count_q != NW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + NW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- src/dda_back.sv -----
`default_nettype none

// carries out queued commands: loads or advances the positions and
// registers one result per command
module dda_back #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  output logic                         pop_ready_o,
  input  dda_pkg::dda_cmd_e            pop_kind_i,
  input  logic signed [COORD_BITS-1:0] pop_xa_i,
  input  logic signed [COORD_BITS-1:0] pop_ya_i,
  input  logic signed [FRAC_BITS+1:0]  pop_xinc_i,
  input  logic signed [FRAC_BITS+1:0]  pop_yinc_i,
  input  logic [COORD_BITS-1:0]        pop_steps_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         pixel_valid_o,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic                         last_pixel_o
);

  import dda_pkg::*;

  localparam int unsigned PW = COORD_BITS + FRAC_BITS + 1;

  // positions are kept with the rounding half already added
  logic signed [PW-1:0]          posx_q, posx_d, posy_q, posy_d;
  logic signed [PW-1:0]          sumx, sumy;
  logic signed [FRAC_BITS+1:0]   incx_q, incx_d, incy_q, incy_d;
  logic [COORD_BITS-1:0]         left_q, left_d;
  logic                          active_q, active_d;
  logic                          ovalid_q, ovalid_d;
  logic                          pv_q, pv_d, last_q, last_d;
  logic signed [COORD_BITS-1:0]  px_q, px_d, py_q, py_d;
  logic                          pop;

  assign pop_ready_o = !ovalid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;

  assign sumx = posx_q + {{(PW-FRAC_BITS-2){incx_q[FRAC_BITS+1]}}, incx_q};
  assign sumy = posy_q + {{(PW-FRAC_BITS-2){incy_q[FRAC_BITS+1]}}, incy_q};

  always_comb begin
    posx_d   = posx_q;
    posy_d   = posy_q;
    incx_d   = incx_q;
    incy_d   = incy_q;
    left_d   = left_q;
    active_d = active_q;
    ovalid_d = ovalid_q;
    pv_d     = pv_q;
    px_d     = px_q;
    py_d     = py_q;
    last_d   = last_q;
    if (pop) begin
      ovalid_d = 1'b1;
      case (pop_kind_i)
        CMD_START: begin
          posx_d   = {pop_xa_i[COORD_BITS-1], pop_xa_i, 1'b1, {(FRAC_BITS-1){1'b0}}};
          posy_d   = {pop_ya_i[COORD_BITS-1], pop_ya_i, 1'b1, {(FRAC_BITS-1){1'b0}}};
          incx_d   = pop_xinc_i;
          incy_d   = pop_yinc_i;
          left_d   = pop_steps_i;
          active_d = pop_steps_i != '0;
          pv_d     = 1'b1;
          px_d     = pop_xa_i;
          py_d     = pop_ya_i;
          last_d   = pop_steps_i == '0;
        end
        CMD_STEP: begin
          if (active_q) begin
            posx_d   = sumx;
            posy_d   = sumy;
            left_d   = left_q - COORD_BITS'(1);
            active_d = left_q != COORD_BITS'(1);
            pv_d     = 1'b1;
            px_d     = sumx[FRAC_BITS +: COORD_BITS];
            py_d     = sumy[FRAC_BITS +: COORD_BITS];
            last_d   = left_q == COORD_BITS'(1);
          end else begin
            pv_d   = 1'b0;
            px_d   = '0;
            py_d   = '0;
            last_d = 1'b0;
          end
        end
        default: begin
          pv_d   = 1'b0;
          px_d   = '0;
          py_d   = '0;
          last_d = 1'b0;
        end
      endcase
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ovalid_q <= 1'b0;
      left_q   <= '0;
    end else begin
      active_q <= active_d;
      ovalid_q <= ovalid_d;
      left_q   <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    posx_q <= posx_d;
    posy_q <= posy_d;
    incx_q <= incx_d;
    incy_q <= incy_d;
    pv_q   <= pv_d;
    px_q   <= px_d;
    py_q   <= py_d;
    last_q <= last_d;
  end

  assign out_valid_o   = ovalid_q;
  assign pixel_valid_o = pv_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign last_pixel_o  = last_q;

  // a line in progress always has steps left to take
  a_active_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (left_q != '0))
    else $error("line active with no steps left");

endmodule

`default_nettype wire

// ----- src/dda_line_rasterizer_core.sv -----
// DDA line rasterizer. A start item (tuser = 0) latches two signed endpoints
// from tdata and answers with the first pixel, which is the start point; a
// zero-length line gives that one pixel with tlast set. Each step item
// (tuser = 1) advances the line by one pixel; the end point comes out with
// tlast set. A step item with no line in progress answers with tuser = 0 and
// all-zero data. Every item gives exactly one result. Pixels are
// floor(position + 0.5) of Q(COORD_BITS).(FRAC_BITS) positions, and the
// increments are delta / max(|dx|, |dy|) rounded to nearest. A run of step
// items flows at one pixel per clock while the queue has room and the output
// is not held back. A start item holds the input while the front part goes
// through three setup steps for deltas, magnitudes and step count, one load
// step, the two bit-serial increment dividers and their done flag, and the
// hand-off of the command to the back part. A zero-length line skips the
// dividers. A full queue stretches the hand-off until an entry frees up.
`default_nettype none

module dda_line_rasterizer_core #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16,
  localparam int unsigned IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input items
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // x_start, y_start, x_end, y_end, zero pad
  input  logic             s_axis_tuser,   // func
  // result items
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // pixel_x, pixel_y, zero pad
  output logic             m_axis_tuser,   // pixel_valid
  output logic             m_axis_tlast    // last_pixel
);

  import dda_pkg::*;

  // queue entry: kind, steps, y increment, x increment, start y, start x
  localparam int unsigned QW = 1 + 3 * COORD_BITS + 2 * (FRAC_BITS + 2);

  logic                         push_valid, push_ready;
  dda_cmd_e                     push_kind, pop_kind;
  logic signed [COORD_BITS-1:0] push_xa, push_ya, pop_xa, pop_ya;
  logic signed [FRAC_BITS+1:0]  push_xinc, push_yinc, pop_xinc, pop_yinc;
  logic [COORD_BITS-1:0]        push_steps, pop_steps;
  logic [QW-1:0]                push_data, pop_data;
  logic                         pop_valid, pop_ready;
  logic signed [COORD_BITS-1:0] pixel_x, pixel_y;

  // front: takes items, sets up lines, runs the increment divisions
  dda_front #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .func_i      (s_axis_tuser),
    .x_start_i   (s_axis_tdata[COORD_BITS-1:0]),
    .y_start_i   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .x_end_i     (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .y_end_i     (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_kind_o (push_kind),
    .push_xa_o   (push_xa),
    .push_ya_o   (push_ya),
    .push_xinc_o (push_xinc),
    .push_yinc_o (push_yinc),
    .push_steps_o(push_steps)
  );

  assign push_data = {push_kind, push_steps, push_yinc, push_xinc, push_ya, push_xa};

  // short queue so the front can set up a line while the back still stalls
  dda_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  assign pop_xa    = pop_data[COORD_BITS-1:0];
  assign pop_ya    = pop_data[2*COORD_BITS-1:COORD_BITS];
  assign pop_xinc  = pop_data[2*COORD_BITS+FRAC_BITS+1:2*COORD_BITS];
  assign pop_yinc  = pop_data[2*COORD_BITS+2*FRAC_BITS+3:2*COORD_BITS+FRAC_BITS+2];
  assign pop_steps = pop_data[QW-2:QW-1-COORD_BITS];
  assign pop_kind  = dda_cmd_e'(pop_data[QW-1]);

  // back: position accumulators and the output register
  dda_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_kind_i   (pop_kind),
    .pop_xa_i     (pop_xa),
    .pop_ya_i     (pop_ya),
    .pop_xinc_i   (pop_xinc),
    .pop_yinc_i   (pop_yinc),
    .pop_steps_i  (pop_steps),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .pixel_valid_o(m_axis_tuser),
    .pixel_x_o    (pixel_x),
    .pixel_y_o    (pixel_y),
    .last_pixel_o (m_axis_tlast)
  );

  // pad the result up to whole bytes
  assign m_axis_tdata = OUT_W'({pixel_y, pixel_x});

endmodule

`default_nettype wire
